@@ rtl/core/cfpm_pkg.sv @@
package cfpm_pkg;

  localparam int PatternMax = 32;
  localparam int PosSat     = 33;
  localparam int FieldSat   = 15;

  localparam logic [7:0] SepByte = 8'd44;
  localparam logic [7:0] EolByte = 8'd10;

  typedef logic [7:0]  text_byte_t;
  typedef logic [15:0] line_index_t;
  typedef logic [63:0] cfg_data_t;
  typedef logic [5:0]  cfg_addr_t;

  typedef enum logic [2:0] {
    RegMatchColumn   = 3'd0,
    RegCaseSensitive = 3'd1,
    RegPatternLength = 3'd2,
    RegPatternWord0  = 3'd3,
    RegPatternWord1  = 3'd4,
    RegPatternWord2  = 3'd5,
    RegPatternWord3  = 3'd6
  } cfg_reg_t;

  // ASCII upper case to lower case, everything else unchanged
  function automatic text_byte_t fold_byte(input text_byte_t b);
    text_byte_t r;
    r = b;
    if (b inside {[8'd65:8'd90]}) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/cfpm_in_if.sv @@
interface cfpm_in_if;
  logic                  valid;
  logic                  ready;
  cfpm_pkg::text_byte_t  data_byte;
  logic                  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/core/cfpm_out_if.sv @@
interface cfpm_out_if;
  logic                   valid;
  logic                   ready;
  logic                   line_match;
  cfpm_pkg::line_index_t  line_index;

  modport source (output valid, output line_match, output line_index, input ready);
  modport sink   (input valid, input line_match, input line_index, output ready);
endinterface

@@ rtl/core/csv_field_pattern_matcher.sv @@
// CSV column filter: takes one text byte per cycle, splits lines at commas (empty fields are
// skipped and not counted), compares the non-empty field numbered match_column with a pattern
// of up to 32 bytes, exactly or ASCII case-insensitively, and at each newline or last-flagged
// byte returns one word holding the line's match flag and a wrapping 16-bit line number.
// Throughput is one byte per cycle while input is not held off: all field tracking and the
// byte compare sit in one stage behind the field-state registers. The byte that ends a line
// writes its result into a two-entry output buffer (main entry, or skid entry while the main
// entry is not taken), so input is held off only while both entries are occupied. Configuration
// registers are 64 bits at byte address 8*index and must be written while no line is in flight.
module csv_field_pattern_matcher (
  input  logic                 clk,
  input  logic                 rst_n,
  cfpm_in_if.sink              in_ch,
  cfpm_out_if.source           out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  cfpm_pkg::cfg_addr_t  paddr,
  input  cfpm_pkg::cfg_data_t  pwdata,
  output cfpm_pkg::cfg_data_t  prdata,
  output logic                 pready
);

  // configuration
  logic [3:0]        match_column_r;
  logic              case_sensitive_r;
  logic [5:0]        pattern_length_r;
  logic [3:0][63:0]  pattern_words_r;
  logic [31:0][7:0]  pattern_bytes;
  logic              cfg_write;
  cfpm_pkg::cfg_reg_t cfg_sel;

  // line state
  logic [3:0]  field_counter_r,     field_counter_nxt;
  logic [5:0]  char_position_r,     char_position_nxt;
  logic        in_field_r,          in_field_nxt;
  logic        field_still_equal_r, field_still_equal_nxt;
  logic        line_matched_r,      line_matched_nxt;
  logic [15:0] line_counter_r,      line_counter_nxt;

  // output buffer
  logic        out_valid_r, skid_valid_r;
  logic        out_match_r, skid_match_r;
  logic [15:0] out_index_r, skid_index_r;

  logic        accept, push, pop;
  logic        is_eol, is_sep, line_end;
  logic        plen_ok, hit_open, hit_after;
  logic [3:0]  fc_start, fc_a;
  logic [5:0]  cp_start, cp_text, cp_a;
  logic        eq_start, eq_text, eq_a, inf_a, lm_a;
  logic        in_range, byte_eq;
  logic [7:0]  pat_b, txt_b;
  logic        res_match;

  assign pattern_bytes = pattern_words_r;
  assign cfg_write     = psel & penable & pwrite & pready;
  assign cfg_sel       = cfpm_pkg::cfg_reg_t'(paddr[5:3]);
  assign pready        = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_column_r   <= 4'd1;
      case_sensitive_r <= 1'b0;
      pattern_length_r <= '0;
      pattern_words_r  <= '0;
    end else if (cfg_write) begin
      case (cfg_sel)
        cfpm_pkg::RegMatchColumn:   match_column_r     <= pwdata[3:0];
        cfpm_pkg::RegCaseSensitive: case_sensitive_r   <= pwdata[0];
        cfpm_pkg::RegPatternLength: pattern_length_r   <= pwdata[5:0];
        cfpm_pkg::RegPatternWord0:  pattern_words_r[0] <= pwdata;
        cfpm_pkg::RegPatternWord1:  pattern_words_r[1] <= pwdata;
        cfpm_pkg::RegPatternWord2:  pattern_words_r[2] <= pwdata;
        cfpm_pkg::RegPatternWord3:  pattern_words_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      cfpm_pkg::RegMatchColumn:   prdata = {60'd0, match_column_r};
      cfpm_pkg::RegCaseSensitive: prdata = {63'd0, case_sensitive_r};
      cfpm_pkg::RegPatternLength: prdata = {58'd0, pattern_length_r};
      cfpm_pkg::RegPatternWord0:  prdata = pattern_words_r[0];
      cfpm_pkg::RegPatternWord1:  prdata = pattern_words_r[1];
      cfpm_pkg::RegPatternWord2:  prdata = pattern_words_r[2];
      cfpm_pkg::RegPatternWord3:  prdata = pattern_words_r[3];
      default:                    prdata = '0;
    endcase
  end

  // handshake: hold input only when both output entries are taken
  assign in_ch.ready = !skid_valid_r;
  assign accept      = in_ch.valid & in_ch.ready;
  assign pop         = out_valid_r & out_ch.ready;

  assign is_eol   = (in_ch.data_byte == cfpm_pkg::EolByte);
  assign is_sep   = (in_ch.data_byte == cfpm_pkg::SepByte);
  assign line_end = is_eol | in_ch.last_byte;
  assign push     = accept & line_end;

  assign plen_ok  = (pattern_length_r != 6'd0) &&
                    (pattern_length_r <= 6'(cfpm_pkg::PatternMax));
  assign hit_open = in_field_r && (field_counter_r == match_column_r) &&
                    field_still_equal_r && plen_ok &&
                    (char_position_r == pattern_length_r);

  // text byte: open a field if none is open, then compare at the current position
  always_comb begin
    if (in_field_r) begin
      fc_start = field_counter_r;
      cp_start = char_position_r;
      eq_start = field_still_equal_r;
    end else begin
      fc_start = (field_counter_r == 4'(cfpm_pkg::FieldSat)) ? field_counter_r
                                                             : field_counter_r + 4'd1;
      cp_start = '0;
      eq_start = 1'b1;
    end
    in_range = (cp_start < pattern_length_r) && (cp_start < 6'(cfpm_pkg::PatternMax));
    pat_b    = pattern_bytes[cp_start[4:0]];
    txt_b    = in_ch.data_byte;
    if (!case_sensitive_r) begin
      pat_b = cfpm_pkg::fold_byte(pat_b);
      txt_b = cfpm_pkg::fold_byte(txt_b);
    end
    byte_eq  = (pat_b == txt_b);
    eq_text  = eq_start & in_range & byte_eq;
    cp_text  = (cp_start < 6'(cfpm_pkg::PosSat)) ? cp_start + 6'd1 : cp_start;
  end

  // state once the byte itself is taken, before any line end
  always_comb begin
    fc_a  = field_counter_r;
    cp_a  = char_position_r;
    inf_a = in_field_r;
    eq_a  = field_still_equal_r;
    lm_a  = line_matched_r;
    if (is_eol) begin
      // nothing changes; the line end closes the field
    end else if (is_sep) begin
      inf_a = 1'b0;
      lm_a  = line_matched_r | hit_open;
    end else begin
      fc_a  = fc_start;
      cp_a  = cp_text;
      inf_a = 1'b1;
      eq_a  = eq_text;
    end
    hit_after = inf_a && (fc_a == match_column_r) && eq_a && plen_ok &&
                (cp_a == pattern_length_r);
    res_match = lm_a | hit_after;
  end

  always_comb begin
    field_counter_nxt     = field_counter_r;
    char_position_nxt     = char_position_r;
    in_field_nxt          = in_field_r;
    field_still_equal_nxt = field_still_equal_r;
    line_matched_nxt      = line_matched_r;
    line_counter_nxt      = line_counter_r;
    if (accept) begin
      if (line_end) begin
        field_counter_nxt     = '0;
        char_position_nxt     = '0;
        in_field_nxt          = 1'b0;
        field_still_equal_nxt = 1'b1;
        line_matched_nxt      = 1'b0;
        line_counter_nxt      = line_counter_r + 16'd1;
      end else begin
        field_counter_nxt     = fc_a;
        char_position_nxt     = cp_a;
        in_field_nxt          = inf_a;
        field_still_equal_nxt = eq_a;
        line_matched_nxt      = lm_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_counter_r     <= '0;
      char_position_r     <= '0;
      in_field_r          <= 1'b0;
      field_still_equal_r <= 1'b1;
      line_matched_r      <= 1'b0;
      line_counter_r      <= '0;
    end else begin
      field_counter_r     <= field_counter_nxt;
      char_position_r     <= char_position_nxt;
      in_field_r          <= in_field_nxt;
      field_still_equal_r <= field_still_equal_nxt;
      line_matched_r      <= line_matched_nxt;
      line_counter_r      <= line_counter_nxt;
    end
  end

  // output buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // output buffer words
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_match_r <= skid_match_r;
        out_index_r <= skid_index_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_match_r <= res_match;
        skid_index_r <= line_counter_r;
      end else begin
        out_match_r <= res_match;
        out_index_r <= line_counter_r;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_match = out_match_r;
  assign out_ch.line_index = out_index_r;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a main output entry");

  a_line_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (line_counter_r == $past(line_counter_r) + 16'd1))
    else $error("line counter did not advance by one at line end");

  a_open_field_counted: assert property (@(posedge clk) disable iff (!rst_n)
    in_field_r |-> (field_counter_r != 4'd0))
    else $error("open field with zero field count");

  a_position_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    char_position_r <= 6'(cfpm_pkg::PosSat))
    else $error("character position beyond saturation");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !pop |=> skid_valid_r)
    else $error("buffered word dropped while output stalled");

endmodule
